### hdl/brl_pkg.sv
// Shared types, constants and a helper function of the line raster engine.
package brl_pkg;

    // Framebuffer geometry. WORD_BITS is a power of two so that the column
    // splits into word index and bit position by a shift and a mask.
    localparam int WORD_BITS   = 32;
    localparam int FRAME_WORDS = 4096;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int ADDR_W      = $clog2(FRAME_WORDS);

    // Pixel word addresses before the range check: row (11 bits) times
    // stride (6 bits) plus the word column, and wide enough for any ADDR_W.
    localparam int PA_W = 17;

    localparam int COORD_W = 14;
    localparam int ERR_W   = 17;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [COORD_W-1:0]   t_coord;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_WORD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_OP   = 3'd4;

    typedef enum logic [1:0] {
        STP_IDLE,
        STP_PREP,
        STP_RUN
    } t_step_state;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_DRAW,
        CTL_RDATA,
        CTL_FIN
    } t_ctl_state;

    // One point produced by the line stepper.
    typedef struct packed {
        logic   valid;
        t_coord x;
        t_coord y;
    } t_pixel;

    // Per-pixel AND and XOR bits of the logical function for source bit s.
    // Result bit for source s and destination d is bit (3 - (2*s + d)) of rop.
    function automatic logic [1:0] rop_bits(input logic [3:0] rop, input logic s);
        logic a_bit;
        logic x_bit;
        x_bit = s ? rop[1] : rop[3];
        a_bit = s ? (rop[1] ^ rop[0]) : (rop[3] ^ rop[2]);
        return {a_bit, x_bit};
    endfunction

endpackage

### hdl/brl_ram.sv
// Framebuffer word memory: one write port, one read port, registered read data.
module brl_ram (
    input  logic             i_clk,
    input  logic             i_we,
    input  brl_pkg::t_addr   i_waddr,
    input  brl_pkg::t_word   i_wdata,
    input  brl_pkg::t_addr   i_raddr,
    output brl_pkg::t_word   o_rdata
);

    brl_pkg::t_word r_mem [brl_pkg::FRAME_WORDS];
    brl_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/brl_step.sv
// Bresenham line stepper: emits one point of the line per cycle.
module brl_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  brl_pkg::t_coord  i_x_start,
    input  brl_pkg::t_coord  i_y_start,
    input  brl_pkg::t_coord  i_x_end,
    input  brl_pkg::t_coord  i_y_end,
    output brl_pkg::t_pixel  o_pix,
    output logic             o_busy
);

    brl_pkg::t_step_state r_state;
    brl_pkg::t_step_state n_state;

    brl_pkg::t_coord          r_x;
    brl_pkg::t_coord          r_y;
    brl_pkg::t_coord          r_adx;
    brl_pkg::t_coord          r_ady;
    logic                     r_sx_neg;
    logic                     r_sy_neg;
    logic                     r_xmajor;
    brl_pkg::t_coord          r_len;
    logic [brl_pkg::ERR_W-1:0] r_e;
    logic [brl_pkg::ERR_W-1:0] r_e1;
    logic [brl_pkg::ERR_W-1:0] r_e3;

    logic [brl_pkg::COORD_W:0]  dx;
    logic [brl_pkg::COORD_W:0]  dy;
    logic [brl_pkg::COORD_W:0]  dx_abs;
    logic [brl_pkg::COORD_W:0]  dy_abs;
    logic                       xmajor;
    brl_pkg::t_coord            len;
    brl_pkg::t_coord            minor;
    logic [brl_pkg::ERR_W-1:0]  e_sum;
    logic                       step_minor;
    brl_pkg::t_coord            x_step;
    brl_pkg::t_coord            y_step;
    logic                       running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brl_pkg::STP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        running = 1'b0;
        unique case (r_state)
            brl_pkg::STP_IDLE: begin
                if (i_start) begin
                    n_state = brl_pkg::STP_PREP;
                end
            end
            brl_pkg::STP_PREP: begin
                n_state = brl_pkg::STP_RUN;
            end
            brl_pkg::STP_RUN: begin
                if (r_len == '0) begin
                    n_state = brl_pkg::STP_IDLE;
                end else begin
                    running = 1'b1;
                end
            end
            default: n_state = brl_pkg::STP_IDLE;
        endcase
    end

    // Differences and magnitudes, all within 15 bits for 14-bit inputs.
    assign dx     = {i_x_end[brl_pkg::COORD_W-1], i_x_end}
                  - {i_x_start[brl_pkg::COORD_W-1], i_x_start};
    assign dy     = {i_y_end[brl_pkg::COORD_W-1], i_y_end}
                  - {i_y_start[brl_pkg::COORD_W-1], i_y_start};
    assign dx_abs = dx[brl_pkg::COORD_W] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[brl_pkg::COORD_W] ? (~dy + 1'b1) : dy;

    // Ties go to the Y axis.
    assign xmajor = r_adx > r_ady;
    assign len    = xmajor ? r_adx : r_ady;
    assign minor  = xmajor ? r_ady : r_adx;

    assign e_sum      = r_e + r_e1;
    assign step_minor = !e_sum[brl_pkg::ERR_W-1];
    assign x_step     = r_x + (r_sx_neg ? {brl_pkg::COORD_W{1'b1}} : brl_pkg::t_coord'(1));
    assign y_step     = r_y + (r_sy_neg ? {brl_pkg::COORD_W{1'b1}} : brl_pkg::t_coord'(1));

    always_ff @(posedge i_clk) begin
        if (r_state == brl_pkg::STP_IDLE && i_start) begin
            r_x      <= i_x_start;
            r_y      <= i_y_start;
            r_adx    <= dx_abs[brl_pkg::COORD_W-1:0];
            r_ady    <= dy_abs[brl_pkg::COORD_W-1:0];
            r_sx_neg <= dx[brl_pkg::COORD_W];
            r_sy_neg <= dy[brl_pkg::COORD_W];
        end
        if (r_state == brl_pkg::STP_PREP) begin
            r_xmajor <= xmajor;
            r_len    <= len;
            r_e      <= brl_pkg::ERR_W'(0) - {3'b000, len};
            r_e1     <= {2'b00, minor, 1'b0};
            r_e3     <= brl_pkg::ERR_W'(0) - {2'b00, len, 1'b0};
        end
        if (running) begin
            r_len <= r_len - 1'b1;
            r_e   <= step_minor ? (e_sum + r_e3) : e_sum;
            if (r_xmajor) begin
                r_x <= x_step;
                if (step_minor) begin
                    r_y <= y_step;
                end
            end else begin
                r_y <= y_step;
                if (step_minor) begin
                    r_x <= x_step;
                end
            end
        end
    end

    assign o_pix.valid = running;
    assign o_pix.x     = r_x;
    assign o_pix.y     = r_y;
    assign o_busy      = (r_state != brl_pkg::STP_IDLE);

endmodule

### hdl/bresenham_line_raster_op_unit.sv
// Top level of the line raster engine: control, pixel read-modify-write and ports.
//
// Usage. Items arrive on the input channel (i_in_valid, o_in_stall) and each one
// produces exactly one transfer on the output channel (o_out_valid, i_out_stall).
// A draw item runs a Bresenham line from the start point up to, but not
// including, the end point, and applies the raster op to every point that lies
// inside the clip region and maps to a word of the framebuffer. A read item
// returns the framebuffer word at word_address; a write item stores write_data
// there. Draw, write and unused items return zero. The block works on one item
// at a time: o_in_stall is high from the transfer of an item until its result
// has moved into the output register. That register holds the result while the
// receiver stalls, and the next item is taken meanwhile.
// While a line is drawn, the stepper visits one point per cycle and the memory
// does one read and one write per cycle, with a forward path when two
// neighboring points share a word.
// Reset (synchronous, active low) returns the registers to their defaults and
// empties the control path; the framebuffer is not cleared and holds undefined
// data until written. Configuration writes must be made only while the block is
// idle; the block itself does not enforce this.
module bresenham_line_raster_op_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_action,
    input  logic [brl_pkg::COORD_W-1:0]      i_x_start,
    input  logic [brl_pkg::COORD_W-1:0]      i_y_start,
    input  logic [brl_pkg::COORD_W-1:0]      i_x_end,
    input  logic [brl_pkg::COORD_W-1:0]      i_y_end,
    input  logic [11:0]                      i_word_address,
    input  logic [brl_pkg::DATA_W-1:0]       i_write_data,
    // Output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [brl_pkg::DATA_W-1:0]       o_read_data,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [brl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [brl_pkg::DATA_W-1:0]       i_cfg_data
);

    // Configuration registers.
    logic [10:0]                 r_clip_width;
    logic [10:0]                 r_clip_height;
    logic [5:0]                  r_row_stride;
    logic [brl_pkg::DATA_W-1:0]  r_fill_word;
    logic [3:0]                  r_raster_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_width  <= 11'd128;
            r_clip_height <= 11'd64;
            r_row_stride  <= 6'd4;
            r_fill_word   <= '1;
            r_raster_op   <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                brl_pkg::CFG_CLIP_WIDTH:  r_clip_width  <= i_cfg_data[10:0];
                brl_pkg::CFG_CLIP_HEIGHT: r_clip_height <= i_cfg_data[10:0];
                brl_pkg::CFG_ROW_STRIDE:  r_row_stride  <= i_cfg_data[5:0];
                brl_pkg::CFG_FILL_WORD:   r_fill_word   <= i_cfg_data;
                brl_pkg::CFG_RASTER_OP:   r_raster_op   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Control state and result registers.
    brl_pkg::t_ctl_state r_state;
    brl_pkg::t_ctl_state n_state;
    logic [brl_pkg::DATA_W-1:0] r_res;
    logic [brl_pkg::DATA_W-1:0] n_res;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [brl_pkg::DATA_W-1:0] r_out_data;
    logic [brl_pkg::DATA_W-1:0] n_out_data;

    logic in_xfer;
    logic out_free;
    logic step_start;

    brl_pkg::t_action in_action;

    assign in_action  = brl_pkg::t_action'(i_action);
    assign o_in_stall = (r_state != brl_pkg::CTL_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_start = in_xfer && (in_action == brl_pkg::ACT_DRAW);

    // Line stepper.
    brl_pkg::t_pixel step_pix;
    logic            step_busy;

    brl_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (step_start),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_pix     (step_pix),
        .o_busy    (step_busy)
    );

    // Point stage: clip test, word address and source bit. The memory read for
    // the point is issued in this cycle.
    logic                            pix_in_x;
    logic                            pix_in_y;
    logic [brl_pkg::PA_W-1:0]        pix_addr;
    logic                            pix_ok;
    logic [brl_pkg::BIT_W-1:0]       pix_pos;
    brl_pkg::t_word                  fill_ext;
    logic [1:0]                      pix_ax;

    assign pix_in_x = !step_pix.x[brl_pkg::COORD_W-1]
                   && (step_pix.x[brl_pkg::COORD_W-2:0] < {2'b00, r_clip_width});
    assign pix_in_y = !step_pix.y[brl_pkg::COORD_W-1]
                   && (step_pix.y[brl_pkg::COORD_W-2:0] < {2'b00, r_clip_height});
    assign pix_addr = brl_pkg::PA_W'(step_pix.y[10:0]) * brl_pkg::PA_W'(r_row_stride)
                    + brl_pkg::PA_W'(step_pix.x[brl_pkg::COORD_W-2:brl_pkg::BIT_W]);
    assign pix_ok   = step_pix.valid && pix_in_x && pix_in_y
                   && (pix_addr < brl_pkg::PA_W'(brl_pkg::FRAME_WORDS));
    assign pix_pos  = step_pix.x[brl_pkg::BIT_W-1:0];
    assign fill_ext = brl_pkg::t_word'(r_fill_word);
    assign pix_ax   = brl_pkg::rop_bits(r_raster_op, fill_ext[pix_pos]);

    // Modify stage registers.
    logic                      r_p1_valid;
    brl_pkg::t_addr            r_p1_addr;
    logic [brl_pkg::BIT_W-1:0] r_p1_pos;
    logic [1:0]                r_p1_ax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= pix_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr <= pix_addr[brl_pkg::ADDR_W-1:0];
        r_p1_pos  <= pix_pos;
        r_p1_ax   <= pix_ax;
    end

    // Memory port control.
    logic                      mem_we;
    brl_pkg::t_addr            mem_waddr;
    brl_pkg::t_word            mem_wdata;
    logic                      mem_re;
    brl_pkg::t_addr            mem_raddr;
    brl_pkg::t_word            mem_rdata;
    logic                      r_fwd;
    brl_pkg::t_word            r_fwd_data;
    brl_pkg::t_word            dst_word;
    brl_pkg::t_word            pix_mask;
    logic                      new_bit;
    logic [brl_pkg::PA_W-1:0]  cmd_addr;
    logic                      cmd_addr_ok;

    assign cmd_addr    = brl_pkg::PA_W'(i_word_address);
    assign cmd_addr_ok = cmd_addr < brl_pkg::PA_W'(brl_pkg::FRAME_WORDS);

    // A point whose word was written in the cycle its read was issued sees the
    // old memory contents, so it takes the word just written instead.
    assign dst_word = r_fwd ? r_fwd_data : mem_rdata;
    assign pix_mask = brl_pkg::t_word'(1) << r_p1_pos;
    assign new_bit  = (dst_word[r_p1_pos] & r_p1_ax[1]) ^ r_p1_ax[0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p1_addr;
        mem_wdata = (dst_word & ~pix_mask) | (pix_mask & {brl_pkg::WORD_BITS{new_bit}});
        mem_re    = pix_ok;
        mem_raddr = pix_addr[brl_pkg::ADDR_W-1:0];
        if (r_p1_valid) begin
            mem_we = 1'b1;
        end else if (in_xfer && in_action == brl_pkg::ACT_WRITE && cmd_addr_ok) begin
            mem_we    = 1'b1;
            mem_waddr = cmd_addr[brl_pkg::ADDR_W-1:0];
            mem_wdata = brl_pkg::t_word'(i_write_data);
        end
        if (in_xfer && in_action == brl_pkg::ACT_READ) begin
            mem_re    = cmd_addr_ok;
            mem_raddr = cmd_addr[brl_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= mem_we && mem_re && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= mem_wdata;
    end

    brl_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Read results out of range answer zero; remember whether the word exists.
    logic r_rd_ok;

    always_ff @(posedge i_clk) begin
        r_rd_ok <= cmd_addr_ok;
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brl_pkg::CTL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            brl_pkg::CTL_IDLE: begin
                if (in_xfer) begin
                    n_res = '0;
                    unique case (in_action)
                        brl_pkg::ACT_DRAW:  n_state = brl_pkg::CTL_DRAW;
                        brl_pkg::ACT_READ:  n_state = brl_pkg::CTL_RDATA;
                        brl_pkg::ACT_WRITE: n_state = brl_pkg::CTL_FIN;
                        brl_pkg::ACT_NONE:  n_state = brl_pkg::CTL_FIN;
                        default:            n_state = brl_pkg::CTL_FIN;
                    endcase
                end
            end
            brl_pkg::CTL_DRAW: begin
                // The stepper leaves its run state and returns to idle after its last point,
                // by which time that point's write has reached the memory.
                if (!step_busy) begin
                    n_state = brl_pkg::CTL_FIN;
                end
            end
            brl_pkg::CTL_RDATA: begin
                n_res   = r_rd_ok ? brl_pkg::DATA_W'(dst_word) : '0;
                n_state = brl_pkg::CTL_FIN;
            end
            brl_pkg::CTL_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = brl_pkg::CTL_IDLE;
                end
            end
            default: n_state = brl_pkg::CTL_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // A pending pixel write belongs to the line currently being drawn.
    a_p1_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_state == brl_pkg::CTL_DRAW))
        else $error("pixel write outside a draw");

    // The stepper only produces points while the sequencer waits on it.
    a_step_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_pix.valid |-> (r_state == brl_pkg::CTL_DRAW) && step_busy)
        else $error("stepper point outside a draw");

    // Forwarding only ever serves a point that is being modified.
    a_fwd_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_p1_valid)
        else $error("forwarded word with no pixel to modify");

    // A result enters the output register only when the previous one has left.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid && $stable(r_out_data))
        else $error("output result overwritten while stalled");

endmodule

### sim/testbench.sv
// Self-checking testbench of the line raster engine: directed and random items against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One input item as it is presented on the input channel.
    typedef struct {
        brl_pkg::t_action           act;
        brl_pkg::t_coord            x0;
        brl_pkg::t_coord            y0;
        brl_pkg::t_coord            x1;
        brl_pkg::t_coord            y1;
        logic [11:0]                addr;
        logic [brl_pkg::DATA_W-1:0] wdata;
    } t_frame_item;

    // Behavioral copy of the engine: register file, framebuffer and the queue of
    // read_data words still owed by the block, oldest first.
    class frame_predictor;
        bit [10:0]                   clip_w = 11'd128;
        bit [10:0]                   clip_h = 11'd64;
        bit [5:0]                    stride = 6'd4;
        bit [brl_pkg::DATA_W-1:0]    fill = '1;
        bit [3:0]                    rop = 4'd3;
        bit [brl_pkg::WORD_BITS-1:0] frame [brl_pkg::FRAME_WORDS];
        bit                          written [brl_pkg::FRAME_WORDS];
        logic [11:0]                 written_list [$];
        bit [brl_pkg::DATA_W-1:0]    read_data_due [$];
        int                          mismatches = 0;

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_register(input logic [brl_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [brl_pkg::DATA_W-1:0] value);
            case (idx)
                brl_pkg::CFG_CLIP_WIDTH:  clip_w = value[10:0];
                brl_pkg::CFG_CLIP_HEIGHT: clip_h = value[10:0];
                brl_pkg::CFG_ROW_STRIDE:  stride = value[5:0];
                brl_pkg::CFG_FILL_WORD:   fill = value;
                brl_pkg::CFG_RASTER_OP:   rop = value[3:0];
                default: ;
            endcase
        endfunction

        // Read-modify-write of one pixel; points outside the clip region and
        // words past the end of memory are skipped.
        function void plot_pixel(input int x, input int y,
                                 input bit [brl_pkg::WORD_BITS-1:0] and_w,
                                 input bit [brl_pkg::WORD_BITS-1:0] xor_w);
            int                          waddr;
            bit [brl_pkg::WORD_BITS-1:0] m;
            if (x < 0 || y < 0 || x >= int'(clip_w) || y >= int'(clip_h))
                return;
            waddr = y * int'(stride) + x / brl_pkg::WORD_BITS;
            if (waddr >= brl_pkg::FRAME_WORDS)
                return;
            m = '0;
            m[x % brl_pkg::WORD_BITS] = 1'b1;
            frame[waddr] = (frame[waddr] & (and_w | ~m)) ^ (xor_w & m);
        endfunction

        // Bresenham walk from the start point, the end point excluded; a tie
        // between the axes makes Y the major one.
        function void apply_line(input t_frame_item it);
            int                          x, y, dx, dy, sx, sy, steps, err, err_inc, err_dec;
            bit                          xmaj;
            bit [brl_pkg::WORD_BITS-1:0] and_w, xor_w;
            x = int'($signed(it.x0));
            y = int'($signed(it.y0));
            dx = int'($signed(it.x1)) - x;
            dy = int'($signed(it.y1)) - y;
            sx = 1;
            sy = 1;
            if (dx < 0) begin
                dx = -dx;
                sx = -1;
            end
            if (dy < 0) begin
                dy = -dy;
                sy = -1;
            end
            xmaj = dx > dy;
            steps = xmaj ? dx : dy;
            err = -steps;
            err_inc = 2 * (xmaj ? dy : dx);
            err_dec = -2 * steps;
            // Per bit: d' = (d & a) ^ x, with a and x picked by the fill bit.
            xor_w = (fill & {brl_pkg::WORD_BITS{rop[1]}})
                  | (~fill & {brl_pkg::WORD_BITS{rop[3]}});
            and_w = (fill & {brl_pkg::WORD_BITS{rop[1] ^ rop[0]}}) |
                    (~fill & {brl_pkg::WORD_BITS{rop[3] ^ rop[2]}});
            for (int i = 0; i < steps; i++) begin
                plot_pixel(x, y, and_w, xor_w);
                err += err_inc;
                if (xmaj) begin
                    x += sx;
                    if (err >= 0) begin
                        y += sy;
                        err += err_dec;
                    end
                end else begin
                    y += sy;
                    if (err >= 0) begin
                        x += sx;
                        err += err_dec;
                    end
                end
            end
        endfunction

        // Called at the edge where an item transfers into the block.
        function void take_item(input t_frame_item it);
            case (it.act)
                brl_pkg::ACT_DRAW: begin
                    apply_line(it);
                    read_data_due.push_back('0);
                end
                brl_pkg::ACT_READ: read_data_due.push_back(frame[it.addr]);
                brl_pkg::ACT_WRITE: begin
                    frame[it.addr] = it.wdata;
                    if (!written[it.addr]) begin
                        written[it.addr] = 1'b1;
                        written_list.push_back(it.addr);
                    end
                    read_data_due.push_back('0);
                end
                default: read_data_due.push_back('0);
            endcase
        endfunction

        task check_read_data(input logic [brl_pkg::DATA_W-1:0] got);
            bit [brl_pkg::DATA_W-1:0] due;
            if (read_data_due.size() == 0) begin
                report($sformatf("result 0x%08h with nothing outstanding", got));
            end else begin
                due = read_data_due.pop_front();
                if (got !== due)
                    report($sformatf("read_data 0x%08h, predicted 0x%08h", got, due));
            end
        endtask
    endclass

    // Ports of the block. Every input starts at a known value.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_action = '0;
    brl_pkg::t_coord               i_x_start = '0;
    brl_pkg::t_coord               i_y_start = '0;
    brl_pkg::t_coord               i_x_end = '0;
    brl_pkg::t_coord               i_y_end = '0;
    logic [11:0]                   i_word_address = '0;
    logic [brl_pkg::DATA_W-1:0]    i_write_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [brl_pkg::DATA_W-1:0]    o_read_data;
    logic                          i_cfg_we = 1'b0;
    logic [brl_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [brl_pkg::DATA_W-1:0]    i_cfg_data = '0;

    frame_predictor sb = new;

    // Sender burst state: a burst of transfers, then a random gap.
    int burst_left = 0;
    int gap_left = 0;
    // Budget of very long lines in the random part, which span much of the coordinate range.
    int long_left = 6;
    // Receiver stall pattern: each mode is held for a run of random length.
    int stall_mode = 0;
    int stall_run = 0;

    bresenham_line_raster_op_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_word_address (i_word_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Output side. Outputs are read right after the edge, before any register
    // of the block has updated, so they hold the values seen by that edge. The
    // stall for the next edge is then chosen from the current mode: never
    // stall, stall half the time, stall mostly, or alternate every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_read_data(o_read_data);
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(16, 96);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ~i_out_stall;
        endcase
    end

    // Clamp to the signed 14-bit coordinate range.
    function automatic brl_pkg::t_coord to_coord(input int v);
        int c;
        c = (v < -8192) ? -8192 : ((v > 8191) ? 8191 : v);
        return c[brl_pkg::COORD_W-1:0];
    endfunction

    // Presents one item and returns at the edge where it transfers. A new
    // burst starts with a gap of random length, sometimes none at all.
    task automatic send_item(input t_frame_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_action       <= it.act;
        i_x_start      <= it.x0;
        i_y_start      <= it.y0;
        i_x_end        <= it.x1;
        i_y_end        <= it.y1;
        i_word_address <= it.addr;
        i_write_data   <= it.wdata;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.take_item(it);
        burst_left--;
    endtask

    // Unused fields of line, write and read items mostly carry random values so that their bits toggle.
    task automatic send_action(input brl_pkg::t_action act, input int x0, input int y0,
                               input int x1, input int y1, input logic [11:0] addr,
                               input logic [brl_pkg::DATA_W-1:0] wdata);
        t_frame_item it;
        it.act = act;
        it.x0 = to_coord(x0);
        it.y0 = to_coord(y0);
        it.x1 = to_coord(x1);
        it.y1 = to_coord(y1);
        it.addr = addr;
        it.wdata = wdata;
        send_item(it);
    endtask

    task automatic do_line(input int x0, input int y0, input int x1, input int y1);
        send_action(brl_pkg::ACT_DRAW, x0, y0, x1, y1, 12'($urandom), $urandom);
    endtask

    task automatic do_write(input logic [11:0] addr,
                            input logic [brl_pkg::DATA_W-1:0] wdata);
        send_action(brl_pkg::ACT_WRITE, $urandom_range(0, 16383) - 8192,
                    $urandom_range(0, 16383) - 8192,
                    $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                    addr, wdata);
    endtask

    // Reads go only to words that a write transfer has stored, since the
    // framebuffer holds undefined data until then.
    task automatic do_read(input logic [11:0] addr);
        send_action(brl_pkg::ACT_READ, $urandom_range(0, 16383) - 8192, 0, 0,
                    $urandom_range(0, 16383) - 8192, addr, $urandom);
    endtask

    // Lowers valid, lets every owed result arrive, then lets the engine settle
    // before its registers are touched.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.read_data_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic put_reg(input logic [brl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brl_pkg::DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic program_regs(input int unsigned cw, input int unsigned ch,
                                input int unsigned rs, input int unsigned fw,
                                input int unsigned ro);
        put_reg(brl_pkg::CFG_CLIP_WIDTH, cw);
        put_reg(brl_pkg::CFG_CLIP_HEIGHT, ch);
        put_reg(brl_pkg::CFG_ROW_STRIDE, rs);
        put_reg(brl_pkg::CFG_FILL_WORD, fw);
        put_reg(brl_pkg::CFG_RASTER_OP, ro);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random lines: most start around the clip region and are short, some
    // start anywhere in the coordinate range, and a rare few span it.
    // Diagonals, vertical and horizontal lines come up often on purpose.
    task automatic random_line();
        int x0, y0, dx, dy;
        if ($urandom_range(0, 99) < 75) begin
            x0 = int'($urandom_range(0, int'(sb.clip_w) + 8)) - 4;
            y0 = int'($urandom_range(0, int'(sb.clip_h) + 8)) - 4;
        end else begin
            x0 = int'($urandom_range(0, 16383)) - 8192;
            y0 = int'($urandom_range(0, 16383)) - 8192;
        end
        dx = int'($urandom_range(0, 80)) - 40;
        dy = int'($urandom_range(0, 80)) - 40;
        case ($urandom_range(0, 5))
            0: dy = dx;
            1: dy = -dx;
            2: dx = 0;
            3: dy = 0;
            default: ;
        endcase
        if (long_left > 0 && $urandom_range(0, 99) == 0) begin
            long_left--;
            dx = int'($urandom_range(0, 16383)) - 8192 - x0;
            dy = int'($urandom_range(0, 16383)) - 8192 - y0;
        end
        do_line(x0, y0, x0 + dx, y0 + dy);
    endtask

    // One random item. Writes mostly land in the words that the current clip
    // region maps to, so that lines and reads meet stored data.
    task automatic random_item(input int win);
        int                         pick;
        logic [11:0]                addr;
        logic [brl_pkg::DATA_W-1:0] wdata;
        pick = $urandom_range(0, 99);
        if (pick >= 35 && pick < 65 && sb.written_list.size() != 0) begin
            addr = 12'($urandom_range(0, win - 1));
            if (!sb.written[addr])
                addr = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
            do_read(addr);
        end else if (pick < 35) begin
            random_line();
        end else if (pick < 95) begin
            addr = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, win - 1));
            case ($urandom_range(0, 5))
                0: wdata = '0;
                1: wdata = '1;
                default: wdata = $urandom;
            endcase
            do_write(addr, wdata);
        end else begin
            send_action(brl_pkg::ACT_NONE, $urandom_range(0, 16383) - 8192,
                        $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                        $urandom_range(0, 16383) - 8192, 12'($urandom), $urandom);
        end
    endtask

    // Main sequence. The reset values of the registers (128 by 64, four words
    // per row, all-ones fill, copy) hold during the directed part; then sixteen
    // random phases follow, each with its own register settings and a
    // different raster op, so that every logical function is exercised. Each
    // phase change waits until the block is drained and idle.
    initial begin
        int unsigned cw, ch, rs, fw;
        int          win;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: store known words in the first two rows and at the
        // top of memory.
        do_write(12'd0, 32'h0000_0000);
        do_write(12'd1, 32'hFFFF_FFFF);
        do_write(12'd2, 32'hA5A5_A5A5);
        do_write(12'd3, 32'h0000_0000);
        do_write(12'd4, 32'h0000_0000);
        do_write(12'd5, 32'h5A5A_5A5A);
        do_write(12'd6, 32'h8000_0001);
        do_write(12'd7, 32'hFFFF_FFFF);
        do_write(12'd4095, 32'h1234_5678);
        // A full row running past the right edge of the clip region.
        do_line(0, 0, 130, 0);
        // Right to left, running past the left edge into negative columns.
        do_line(127, 1, -3, 1);
        // Start equal to end: nothing is touched.
        do_line(5, 0, 5, 0);
        // Equal spans on both axes: Y is the major axis.
        do_line(0, 0, 2, 2);
        // Shallow line whose error term decides the row change.
        do_line(0, 1, 7, 0);
        // Extremes of the coordinate range, entirely outside the clip region.
        do_line(-8192, -8192, 8191, -8192);
        do_line(8191, 8191, 8191, -8192);
        do_line(-8192, 8191, 8191, -8192);
        for (int a = 0; a < 8; a++)
            do_read(12'(a));
        do_read(12'd4095);
        send_action(brl_pkg::ACT_NONE, 0, 0, 0, 0, 12'd4095, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 16; phase++) begin
            cw = $urandom_range(1, 160);
            ch = $urandom_range(1, 24);
            rs = $urandom_range(1, 6);
            fw = $urandom;
            case (phase)
                1: cw = 0;
                2: begin
                    // Largest region: most rows map past the end of memory.
                    cw = 1024;
                    ch = 1024;
                    rs = 32;
                end
                3: ch = 0;
                4: begin
                    rs = 1;
                    fw = 0;
                end
                5: begin
                    cw = 1;
                    ch = 1;
                    fw = 32'hFFFF_FFFF;
                end
                6: begin
                    cw = 1024;
                    ch = 4;
                    rs = 32;
                end
                default: ;
            endcase
            // The whole sender holds here until every owed result is in.
            drain();
            program_regs(cw, ch, rs, fw, phase);
            win = int'(ch * rs + rs);
            if (win > brl_pkg::FRAME_WORDS)
                win = brl_pkg::FRAME_WORDS;
            if (ch == 0)
                win = 64;
            repeat (50) random_item(win);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.read_data_due.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: several times the slowest run that the stimulus can make.
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### bresenham_line_raster_op_unit.f
hdl/brl_pkg.sv
hdl/brl_ram.sv
hdl/brl_step.sv
hdl/bresenham_line_raster_op_unit.sv
sim/testbench.sv
